### rtl/egu_pkg.sv
// Shared types, constants and the 2^(-x) lookup table for the exponential gain unit.
// Depends on nothing; imported by egu_frac_exp, exponential_adaptive_gain_unit and tb_top.
package egu_pkg;

	// Table resolution and the split of the Q.24 fraction
	localparam int EXP_TABLE_BITS = 8;
	localparam int TBL_SIZE       = 1 << EXP_TABLE_BITS;
	localparam int FRAC_REST_BITS = 24 - EXP_TABLE_BITS;
	localparam int U_W            = FRAC_REST_BITS + 6;
	localparam int Q30_W          = 31;

	localparam logic [Q30_W-1:0] ONE_Q30   = 31'h4000_0000;
	localparam logic [30:0]      LOG2E_Q30 = 31'd1549082005;
	localparam logic [29:0]      LN2_Q30   = 30'd744261118;
	localparam logic [31:0]      E_MAX     = 32'hFFFF_FFFF;

	// Configuration register indices and reset values
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_SPAN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_RATE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_FLOOR = 2'd2;
	localparam logic [31:0] GAIN_SPAN_RST  = 32'd25155758;
	localparam logic [31:0] DECAY_RATE_RST = 32'd18641351;
	localparam logic [31:0] GAIN_FLOOR_RST = 32'd2795084;

	// Side information that travels with the fraction through the exponential stages
	typedef struct packed {
		logic       big;    // |b*e| too large for the exponent path
		logic       bneg;   // decay coefficient negative: growing exponential
		logic [9:0] shift;  // floor(y) for b >= 0, ceil(y) for b < 0
	} exp_ctl_t;

	typedef logic [Q30_W-1:0] pow_tbl_t [TBL_SIZE];

	// Bitwise integer square root, elaboration only
	function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
		logic [63:0] x;
		logic [63:0] r;
		logic [63:0] bval;
		x    = x_in;
		r    = '0;
		bval = 64'h1 << 62;
		while (bval > x)
			bval = bval >> 2;
		while (bval != 64'h0) begin
			if (x >= r + bval) begin
				x = x - (r + bval);
				r = (r >> 1) + bval;
			end else begin
				r = r >> 1;
			end
			bval = bval >> 2;
		end
		return r;
	endfunction

	// Entry j = 2^(-j/TBL_SIZE) in Q2.30, built from repeated square roots of one half
	function automatic pow_tbl_t build_pow_tbl();
		logic [63:0] roots [EXP_TABLE_BITS+1];
		logic [63:0] v;
		pow_tbl_t    tbl;
		roots[0] = 64'h1 << 29;
		for (int t = 1; t <= EXP_TABLE_BITS; t++)
			roots[t] = isqrt64(roots[t-1] << 30);
		for (int j = 0; j < TBL_SIZE; j++) begin
			v = 64'h1 << 30;
			for (int i = 0; i < EXP_TABLE_BITS; i++)
				if (j[i])
					v = (v * roots[EXP_TABLE_BITS-i] + (64'h1 << 29)) >> 30;
			tbl[j] = v[Q30_W-1:0];
		end
		return tbl;
	endfunction

	localparam pow_tbl_t POW_TBL = build_pow_tbl();

endpackage

### rtl/egu_frac_exp.sv
// Four-stage pipeline forming 2^(-g) in Q2.30 for a Q.24 fraction g.
// Depends on egu_pkg (table, widths, exp_ctl_t).
module egu_frac_exp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [23:0]              in_g,
	input  egu_pkg::exp_ctl_t        in_ctl,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [egu_pkg::Q30_W-1:0] out_q,
	output egu_pkg::exp_ctl_t        out_ctl
);
	import egu_pkg::*;

	logic v_s5, v_s6, v_s7, v_s8;
	logic en5, en6, en7, en8;

	logic [U_W-1:0]   u_s5;
	logic [Q30_W-1:0] t_s5, t_s6, p_s6;
	logic [2*Q30_W-1:0] prod_s7;
	logic [Q30_W-1:0] q_s8;
	exp_ctl_t         ctl_s5, ctl_s6, ctl_s7, ctl_s8;

	logic [EXP_TABLE_BITS-1:0]     idx;
	logic [FRAC_REST_BITS-1:0]     rest;
	logic [FRAC_REST_BITS+29:0]    rest_prod;
	logic [2*U_W-1:0]              uu;
	logic [2*Q30_W-1:0]            q_rnd;

	// stall chain: a stage moves when empty or when the next one moves
	assign en8      = !v_s8 || out_ready;
	assign en7      = !v_s7 || en8;
	assign en6      = !v_s6 || en7;
	assign en5      = !v_s5 || en6;
	assign in_ready = en5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (en5) v_s5 <= in_valid;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
			if (en8) v_s8 <= v_s7;
		end
	end

	// s5: table lookup and linear term u = rest*ln2
	assign idx       = in_g[23:FRAC_REST_BITS];
	assign rest      = in_g[FRAC_REST_BITS-1:0];
	assign rest_prod = rest * LN2_Q30;

	// s6: second-order correction 1 - u + u^2/2
	assign uu = u_s5 * u_s5;

	// s8: round the Q2.30 product
	assign q_rnd = prod_s7 + (62'h1 << 29);

	always_ff @(posedge clk) begin
		if (en5 && in_valid) begin
			u_s5   <= rest_prod[FRAC_REST_BITS+29:24];
			t_s5   <= POW_TBL[idx];
			ctl_s5 <= in_ctl;
		end
		if (en6 && v_s5) begin
			p_s6   <= ONE_Q30 - Q30_W'(u_s5) + Q30_W'(uu >> 31);
			t_s6   <= t_s5;
			ctl_s6 <= ctl_s5;
		end
		if (en7 && v_s6) begin
			prod_s7 <= t_s6 * p_s6;
			ctl_s7  <= ctl_s6;
		end
		if (en8 && v_s7) begin
			q_s8   <= q_rnd[Q30_W+29:30];
			ctl_s8 <= ctl_s7;
		end
	end

	assign out_valid = v_s8;
	assign out_q     = q_s8;
	assign out_ctl   = ctl_s8;

endmodule

### rtl/exponential_adaptive_gain_unit.sv
// Top level of the exponential gain unit: gain = a*exp(-b*e) + c, saturated.
// Depends on egu_pkg and egu_frac_exp.
//
// Usage:
//  - Input stream s_*: one error norm per item, unsigned Q16.16 in s_tdata.
//  - Output stream m_*: one gain per item, signed Q8.24 in m_tdata, and the
//    overflow flag in m_tuser (set when the exponential or the sum saturated).
//  - Config channel cfg_*: index 0 gain_span (a), 1 decay_rate (b),
//    2 gain_floor (c), all signed Q8.24; other indices are dropped. Always
//    ready; write only while no item is in flight.
//  - From input handshake to output valid an item passes the eleven register
//    stages s1 to s11 (six multiplies, each followed by a register).
//  - Throughput is one item per cycle while m_tready is high.
//  - When the receiver stalls, the output register holds its item and the
//    stages behind it fill up; s_tready drops only once every stage is full.
//    Empty stages keep moving, so bubbles are squeezed out.
//  - Reset clears all valid bits and loads the coefficients with their
//    defaults (a about 1.4994, b about 1.1111, c about 0.1666).
module exponential_adaptive_gain_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [31:0]                   s_tdata,    // [31:0] error_norm
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [31:0]                   m_tdata,    // [31:0] gain
	output logic                          m_tuser,    // [0] overflow
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [egu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);
	import egu_pkg::*;

	logic [31:0] gain_span_q, decay_rate_q, gain_floor_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s9, v_s10, v_s11;
	logic en1, en2, en3, en4, en9, en10, en11;

	logic [63:0] p1_s1;
	logic        bneg_s1, bneg_s2, bneg_s3;
	logic [31:0] m_s2;
	logic        big_s2, big_s3;
	logic [62:0] p3_s3;
	logic [23:0] g_s4;
	exp_ctl_t    ctl_s4;
	logic [31:0] e_s9;
	logic        ovf_s9, ovf_s10, ovf_s11;
	logic [63:0] p10_s10;
	logic [31:0] gain_s11;

	logic              fx_ready, fx_valid;
	logic [Q30_W-1:0]  fx_q;
	exp_ctl_t          fx_ctl;

	logic [31:0] bmag;
	logic [63:0] m_rnd;
	logic [63:0] y_rnd;
	logic [32:0] y24;
	logic [8:0]  k_int;
	logic [23:0] f_frac;
	logic [9:0]  kc;
	logic [5:0]  sh;
	logic [40:0] e_pos;
	logic [39:0] e_neg;
	logic [31:0] e_val;
	logic        e_ovf;
	logic [31:0] amag;
	logic [63:0] term_rnd;
	logic signed [41:0] term_s, sum_s;
	logic [31:0] gain_val;
	logic        sum_ovf;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_span_q  <= GAIN_SPAN_RST;
			decay_rate_q <= DECAY_RATE_RST;
			gain_floor_q <= GAIN_FLOOR_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_GAIN_SPAN:  gain_span_q  <= cfg_data;
				REG_DECAY_RATE: decay_rate_q <= cfg_data;
				REG_GAIN_FLOOR: gain_floor_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stall chain, output side first
	assign en11     = !v_s11 || m_tready;
	assign en10     = !v_s10 || en11;
	assign en9      = !v_s9 || en10;
	assign en4      = !v_s4 || fx_ready;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign s_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else begin
			if (en1)  v_s1  <= s_tvalid;
			if (en2)  v_s2  <= v_s1;
			if (en3)  v_s3  <= v_s2;
			if (en4)  v_s4  <= v_s3;
			if (en9)  v_s9  <= fx_valid;
			if (en10) v_s10 <= v_s9;
			if (en11) v_s11 <= v_s10;
		end
	end

	// s1: |b| * e
	assign bmag = decay_rate_q[31] ? (32'h0 - decay_rate_q) : decay_rate_q;

	// s2: round to Q.24, flag exponents beyond 32 bits
	assign m_rnd = p1_s1 + 64'h8000;

	// s4: y = x*log2(e), split into integer and fraction
	assign y_rnd  = {1'b0, p3_s3} + (64'h1 << 29);
	assign y24    = y_rnd[62:30];
	assign k_int  = y24[32:24];
	assign f_frac = y24[23:0];
	assign kc     = {1'b0, k_int} + {9'b0, (f_frac != 24'h0)};

	always_ff @(posedge clk) begin
		if (en1 && s_tvalid) begin
			p1_s1   <= bmag * s_tdata;
			bneg_s1 <= decay_rate_q[31];
		end
		if (en2 && v_s1) begin
			m_s2    <= m_rnd[47:16];
			big_s2  <= |m_rnd[63:48];
			bneg_s2 <= bneg_s1;
		end
		if (en3 && v_s2) begin
			p3_s3   <= m_s2 * LOG2E_Q30;
			big_s3  <= big_s2;
			bneg_s3 <= bneg_s2;
		end
		if (en4 && v_s3) begin
			// growing case uses 2^ceil(y) * 2^-(ceil(y)-y); -f wraps to 0 for f = 0
			g_s4         <= bneg_s3 ? (24'h0 - f_frac) : f_frac;
			ctl_s4.big   <= big_s3;
			ctl_s4.bneg  <= bneg_s3;
			ctl_s4.shift <= bneg_s3 ? kc : {1'b0, k_int};
		end
	end

	// s5..s8: fractional power of two
	egu_frac_exp u_frac_exp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_ready  (fx_ready),
		.in_g      (g_s4),
		.in_ctl    (ctl_s4),
		.out_valid (fx_valid),
		.out_ready (en9),
		.out_q     (fx_q),
		.out_ctl   (fx_ctl)
	);

	// s9: apply the integer shift, with underflow to zero and saturation
	assign sh    = 6'd6 + fx_ctl.shift[5:0];
	assign e_pos = ({10'h0, fx_q} + (41'h1 << (sh - 6'd1))) >> sh;
	assign e_neg = ({9'h0, fx_q} << fx_ctl.shift[3:0]) + 40'd32;

	always_comb begin
		e_val = '0;
		e_ovf = 1'b0;
		priority if (fx_ctl.big) begin
			e_val = fx_ctl.bneg ? E_MAX : 32'h0;
			e_ovf = fx_ctl.bneg;
		end else if (!fx_ctl.bneg) begin
			e_val = (fx_ctl.shift > 10'd34) ? 32'h0 : e_pos[31:0];
		end else if (fx_ctl.shift > 10'd8) begin
			e_val = E_MAX;
			e_ovf = 1'b1;
		end else if (|e_neg[39:38]) begin
			e_val = E_MAX;
			e_ovf = 1'b1;
		end else begin
			e_val = e_neg[37:6];
		end
	end

	// s10: |a| * E
	assign amag = gain_span_q[31] ? (32'h0 - gain_span_q) : gain_span_q;

	// s11: round, restore the sign of a, add c and saturate
	assign term_rnd = p10_s10 + (64'h1 << 23);
	assign term_s   = gain_span_q[31] ? -$signed({2'b00, term_rnd[63:24]})
	                                  : $signed({2'b00, term_rnd[63:24]});
	assign sum_s    = term_s + 42'(signed'(gain_floor_q));

	always_comb begin
		gain_val = sum_s[31:0];
		sum_ovf  = 1'b0;
		priority if (sum_s > 42'sd2147483647) begin
			gain_val = 32'h7FFF_FFFF;
			sum_ovf  = 1'b1;
		end else if (sum_s < -42'sd2147483648) begin
			gain_val = 32'h8000_0000;
			sum_ovf  = 1'b1;
		end else begin
			gain_val = sum_s[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en9 && fx_valid) begin
			e_s9   <= e_val;
			ovf_s9 <= e_ovf;
		end
		if (en10 && v_s9) begin
			p10_s10 <= amag * e_s9;
			ovf_s10 <= ovf_s9;
		end
		if (en11 && v_s10) begin
			gain_s11 <= gain_val;
			ovf_s11  <= ovf_s10 | sum_ovf;
		end
	end

	assign m_tvalid = v_s11;
	assign m_tdata  = gain_s11;
	assign m_tuser  = ovf_s11;

endmodule

### dv/tb_top.sv
// Self-checking testbench for exponential_adaptive_gain_unit: error norms in, gains out.
// Depends on egu_pkg (register indices, reset values, table size) and the unit's RTL.
// Expected gains come from a bit-true fixed-point predictor kept inside this file.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import egu_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int LUT_BITS  = EXP_TABLE_BITS;
	localparam int LUT_SIZE  = 1 << LUT_BITS;
	localparam int REST_BITS = 24 - LUT_BITS;
	localparam longint unsigned Q30_ONE    = 64'd1 << 30;
	localparam longint unsigned Q30_HALF   = 64'd1 << 29;
	localparam longint unsigned LOG2E_FIX  = 64'd1549082005;
	localparam longint unsigned LN2_FIX    = 64'd744261118;
	localparam longint unsigned EXP_CEIL   = 64'hFFFF_FFFF;
	localparam int MAX_PRINTED = 50;

	typedef struct packed {
		logic [31:0] norm;
		logic [31:0] gain;
		logic        ovf;
	} gain_item_t;

	// DUT connections, all inputs known from time zero
	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [31:0]          s_tdata = '0;     // [31:0] error_norm
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [31:0]          m_tdata;          // [31:0] gain
	logic                 m_tuser;          // [0] overflow
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data = '0;

	// Predictor state: coefficient copies and the 2^(-j/N) table
	logic [31:0]       coeff_a = GAIN_SPAN_RST;
	logic [31:0]       coeff_b = DECAY_RATE_RST;
	logic [31:0]       coeff_c = GAIN_FLOOR_RST;
	longint unsigned   pow_lut [LUT_SIZE];
	gain_item_t        pending_gains [$];

	// Run control and bookkeeping
	bit tx_idle_en = 1'b0;
	bit rx_idle_en = 1'b0;
	int rx_hold_req = 0;
	int norms_sent = 0;
	int gains_checked = 0;
	int gains_saturated = 0;
	int coeff_writes = 0;
	int input_held_cycles = 0;
	int mismatches = 0;

	exponential_adaptive_gain_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// Table of 2^(-j/N) in Q2.30 from repeated square roots of one half
	initial begin : build_lut
		longint unsigned roots [LUT_BITS+1];
		longint unsigned v, lo, hi, mid, x;
		roots[0] = Q30_HALF;
		for (int t = 1; t <= LUT_BITS; t++) begin
			// floor(sqrt(x)) by bisection
			x  = roots[t-1] << 30;
			lo = 0;
			hi = 64'h1_0000_0000;
			while (hi - lo > 1) begin
				mid = (lo + hi) >> 1;
				if (mid * mid <= x)
					lo = mid;
				else
					hi = mid;
			end
			roots[t] = lo;
		end
		for (int j = 0; j < LUT_SIZE; j++) begin
			v = Q30_ONE;
			for (int i = 0; i < LUT_BITS; i++)
				if (j[i])
					v = (v * roots[LUT_BITS-i] + Q30_HALF) >> 30;
			pow_lut[j] = v;
		end
	end

	// 2^(-g) in Q2.30 for a Q.24 fraction: table step plus second-order correction
	function automatic longint unsigned exp2_frac(input longint unsigned g);
		longint unsigned idx, rest, u, p;
		idx  = (g >> REST_BITS) & (LUT_SIZE - 1);
		rest = g & ((64'd1 << REST_BITS) - 1);
		u    = (rest * LN2_FIX) >> 24;
		p    = Q30_ONE - u + ((u * u) >> 31);
		return (pow_lut[idx] * p + Q30_HALF) >> 30;
	endfunction

	// Expected gain and overflow for one error norm under the current coefficients
	function automatic gain_item_t predict_gain(input logic [31:0] norm);
		gain_item_t res;
		longint unsigned bmag, amag, m, y24, k, f, kc, g, q, sh, e_val, term;
		longint a_s, b_s, c_s, sum;
		logic bneg, ovf;
		a_s  = longint'($signed(coeff_a));
		b_s  = longint'($signed(coeff_b));
		c_s  = longint'($signed(coeff_c));
		bneg = coeff_b[31];
		bmag = (b_s < 0) ? -b_s : b_s;
		amag = (a_s < 0) ? -a_s : a_s;
		ovf  = 1'b0;

		m = (bmag * norm + 64'h8000) >> 16;
		if (m >= 64'h1_0000_0000) begin
			// exponent far out of range: underflow to zero or saturate upwards
			e_val = bneg ? EXP_CEIL : 64'd0;
			ovf   = bneg;
		end else begin
			y24 = (m * LOG2E_FIX + Q30_HALF) >> 30;
			k   = y24 >> 24;
			f   = y24 & 64'hFF_FFFF;
			if (!bneg) begin
				q     = exp2_frac(f);
				sh    = 64'd6 + k;
				e_val = (sh > 40) ? 64'd0 : ((q + (64'd1 << (sh - 1))) >> sh);
			end else begin
				kc = k + ((f != 0) ? 64'd1 : 64'd0);
				g  = (f != 0) ? ((64'd1 << 24) - f) : 64'd0;
				if (kc > 8) begin
					e_val = EXP_CEIL;
					ovf   = 1'b1;
				end else begin
					q     = exp2_frac(g);
					e_val = ((q << kc) + 64'd32) >> 6;
					if (e_val > EXP_CEIL) begin
						e_val = EXP_CEIL;
						ovf   = 1'b1;
					end
				end
			end
		end

		// scale by |a|, round half away from zero, restore sign, add floor
		term = (amag * e_val + 64'h80_0000) >> 24;
		sum  = coeff_a[31] ? -$signed(term) : $signed(term);
		sum  = sum + c_s;
		if (sum > 64'sd2147483647) begin
			sum = 64'sd2147483647;
			ovf = 1'b1;
		end else if (sum < -64'sd2147483648) begin
			sum = -64'sd2147483648;
			ovf = 1'b1;
		end
		res.norm = norm;
		res.gain = sum[31:0];
		res.ovf  = ovf;
		return res;
	endfunction

	// Gap length: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic logic [31:0] pick_norm();
		case ($urandom_range(0, 15))
			0:       return 32'h0;
			1:       return 32'hFFFF_FFFF;
			2, 3:    return $urandom;
			4, 5:    return $urandom_range(0, 32'h0000_FFFF);
			default: return $urandom_range(0, 32'h0010_0000);
		endcase
	endfunction

	// Coefficients: extremes, full-range noise, and mostly moderate values within +-4.0
	function automatic logic [31:0] pick_coeff();
		logic [31:0] mag;
		case ($urandom_range(0, 11))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2:       return 32'h0;
			3, 4:    return $urandom;
			default: begin
				mag = $urandom_range(0, 32'h0400_0000);
				return $urandom_range(0, 1) ? -mag : mag;
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("[%0t] MISMATCH %s: got %08h, want %08h", $time, what, got, want);
	endtask

	// Send one error norm; called at a rising edge, returns at the accepting edge
	task automatic send_norm(input logic [31:0] norm);
		int  gap;
		bit  ok;
		gap = tx_idle_en ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= norm;
		do begin
			@(negedge clk);
			ok = s_tready;
			if (!ok)
				input_held_cycles++;
			@(posedge clk);
		end while (!ok);
		pending_gains.push_back(predict_gain(norm));
		norms_sent++;
	endtask

	// Write one coefficient register; valid stays high unless this is the last write
	task automatic write_coeff(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val,
			input bit last);
		bit ok;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do begin
			@(negedge clk);
			ok = cfg_ready;
			@(posedge clk);
		end while (!ok);
		if (last)
			cfg_valid <= 1'b0;
		case (idx)
			REG_GAIN_SPAN:  coeff_a = val;
			REG_DECAY_RATE: coeff_b = val;
			REG_GAIN_FLOOR: coeff_c = val;
			default: ;
		endcase
		coeff_writes++;
	endtask

	task automatic load_coeffs(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c);
		write_coeff(REG_GAIN_SPAN, a, 1'b0);
		write_coeff(REG_DECAY_RATE, b, 1'b0);
		write_coeff(REG_GAIN_FLOOR, c, 1'b1);
	endtask

	// Sender pauses until every outstanding gain has come back
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		while (pending_gains.size() != 0)
			@(posedge clk);
	endtask

	// Reset coefficients against the extremes of the norm
	task automatic test_default_coeffs();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		send_norm(32'h0000_0000);
		send_norm(32'h0000_0001);
		send_norm(32'h0000_8000);
		send_norm(32'h0001_0000);
		send_norm(32'h7FFF_FFFF);
		send_norm(32'hFFFF_FFFF);
		wait_for_results();
	endtask

	// Zero decay, saturation both ways, growing exponential, underflow, ignored index
	task automatic test_edge_coeffs();
		// zero decay: exponential is exactly one
		load_coeffs(32'h0180_0000, 32'h0, 32'hFF00_0000);
		send_norm(32'hFFFF_FFFF);
		send_norm(32'h1234_5678);
		wait_for_results();
		// sum saturates high, then low
		load_coeffs(32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF);
		send_norm(32'h0000_0000);
		wait_for_results();
		load_coeffs(32'h8000_0000, 32'h0, 32'h8000_0000);
		send_norm(32'h0004_0000);
		wait_for_results();
		// negative decay: growth, around and beyond the 256.0 ceiling
		load_coeffs(32'h0100_0000, 32'hFF00_0000, 32'h0);
		send_norm(32'h0001_0000);
		send_norm(32'h0005_8B90);
		send_norm(32'h0005_8B98);
		send_norm(32'h0006_0000);
		send_norm(32'hFFFF_FFFF);
		wait_for_results();
		write_coeff(REG_GAIN_SPAN, 32'h7FFF_FFFF, 1'b1);
		send_norm(32'h0002_0000);
		wait_for_results();
		// most negative decay
		load_coeffs(32'h0100_0000, 32'h8000_0000, 32'h0000_1000);
		send_norm(32'hFFFF_FFFF);
		send_norm(32'h0000_0000);
		wait_for_results();
		// steep decay underflows to the floor without overflow
		load_coeffs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_1000);
		send_norm(32'hFFFF_FFFF);
		send_norm(32'h0000_4000);
		wait_for_results();
		// constant gain set-up
		load_coeffs(32'h0, 32'h0100_0000, 32'h0040_0000);
		send_norm(32'h0003_2100);
		wait_for_results();
		// write to the spare index must change nothing
		write_coeff(REG_UNUSED, 32'hFFFF_FFFF, 1'b1);
		send_norm(32'h0000_C000);
		wait_for_results();
	endtask

	// Random coefficient sets, each followed by a burst of random norms
	task automatic test_random_coeffs();
		for (int phase = 0; phase < 15; phase++) begin
			wait_for_results();
			load_coeffs(pick_coeff(), pick_coeff(), pick_coeff());
			tx_idle_en = phase[0];
			rx_idle_en = phase[1];
			for (int n = 0; n < 103; n++)
				send_norm(pick_norm());
		end
		wait_for_results();
	endtask

	// Long receiver hold-off while items keep coming, then a pause and a random tail
	task automatic test_backpressure();
		load_coeffs(GAIN_SPAN_RST, DECAY_RATE_RST, GAIN_FLOOR_RST);
		tx_idle_en  = 1'b0;
		rx_idle_en  = 1'b0;
		rx_hold_req = 150;
		for (int n = 0; n < 60; n++)
			send_norm(pick_norm());
		wait_for_results();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		for (int n = 0; n < 30; n++)
			send_norm(pick_norm());
		wait_for_results();
	endtask

	// Receiver: random stalls when enabled, plus the requested long hold-off
	initial begin : rx_side
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left  = 0;
		forever begin
			@(posedge clk);
			if (rx_hold_req > 0) begin
				hold_left   = rx_hold_req;
				rx_hold_req = 0;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (rx_idle_en && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// Result checker: inputs only move at rising edges, so the negedge view is the
	// value the next rising edge will accept
	initial begin : result_check
		gain_item_t want;
		forever begin
			@(negedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (pending_gains.size() == 0) begin
					report_mismatch("gain with no item outstanding", m_tdata, 32'h0);
				end else begin
					want = pending_gains.pop_front();
					gains_checked++;
					if (m_tuser)
						gains_saturated++;
					if (m_tdata !== want.gain)
						report_mismatch($sformatf("gain, norm %08h", want.norm),
							m_tdata, want.gain);
					if (m_tuser !== want.ovf)
						report_mismatch($sformatf("overflow, norm %08h", want.norm),
							{31'b0, m_tuser}, {31'b0, want.ovf});
				end
			end
		end
	end

	// Test sequence
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_coeffs();
		test_edge_coeffs();
		test_random_coeffs();
		test_backpressure();
		wait_for_results();
		repeat (24) @(posedge clk);
		$display("Sent %0d error norms across %0d coefficient writes; %0d gains checked, %0d flagged.",
			norms_sent, coeff_writes, gains_checked, gains_saturated);
		$display("Input stalled for %0d cycles by output back-pressure; %0d mismatches.",
			input_held_cycles, mismatches);
		if (mismatches == 0 && pending_gains.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog
	initial begin
		#5ms;
		$display("Timed out with %0d gains outstanding", pending_gains.size());
		$display("Verification failed");
		$finish;
	end

endmodule
